// ----- hw/rtl/clfc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame checker.
// No dependencies.

package clfc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [CrcW-1:0] CrcPoly      = 16'h1021;
  localparam logic [CrcW-1:0] CrcInit      = 16'h0000;
  localparam logic [LenW-1:0] MinFrameLen  = 16'd4;
  localparam logic [LenW-1:0] CrcBytes     = 16'd2;
  localparam logic [LenW-1:0] MaxLenReset  = 16'd100;

  // register index, taken from paddr[2]
  localparam logic RegMaxFrameLen = 1'b0;

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY,
    PH_CRC
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_MISMATCH,
    STATUS_SHORT,
    STATUS_LONG
  } status_e;

  function automatic logic [CrcW-1:0] crc16_byte(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crc_length_frame_checker.sv -----
// Length-prefixed CRC-16/XMODEM frame checker, one byte per item.
// A result is registered in the cycle after the byte ending its frame or length check.
// Throughput: one byte per cycle unless a pending result is stalled; the byte-wise
// CRC update and framing logic sit between the framing state and result registers.
// Reset (rst_ni low, asynchronous): framing expects a first length byte, no result
// is pending, max frame length returns to 100. Depends on clfc_pkg, clfc_cfg_regs.

module crc_length_frame_checker import clfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic              sync_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [LenW-1:0]   frame_length_o,
  output logic [CrcW-1:0]   computed_crc_o,
  output logic [CrcW-1:0]   received_crc_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [LenW-1:0] max_len;

  clfc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  phase_e          phase_q, phase_d, phase_cur;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] hi_q, hi_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [LenW-1:0] olen_q, olen_d;
  logic [CrcW-1:0] occ_q, occ_d;
  logic [CrcW-1:0] orc_q, orc_d;

  logic            accept;
  logic            emit;
  logic [CrcW-1:0] crc_upd;
  logic [LenW-1:0] len_lo;
  logic [LenW-1:0] cnt_inc;
  logic [LenW-1:0] crc_pos;
  logic [CrcW-1:0] rx_crc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign phase_cur  = sync_i ? PH_LEN_HI : phase_q;
  assign crc_upd    = crc16_byte((phase_cur == PH_LEN_HI) ? CrcInit : crc_q, rx_byte_i);
  assign len_lo     = len_q | {{(LenW-ByteW){1'b0}}, rx_byte_i};
  assign cnt_inc    = cnt_q + 1'b1;
  assign crc_pos    = len_q - CrcBytes;
  assign rx_crc     = {hi_q, rx_byte_i};

  // next framing state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    crc_d   = crc_q;
    hi_d    = hi_q;
    if (accept) begin
      case (phase_cur)
        PH_LEN_HI: begin
          crc_d   = crc_upd;
          len_d   = {rx_byte_i, {(LenW-ByteW){1'b0}}};
          cnt_d   = 16'd1;
          hi_d    = '0;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          crc_d = crc_upd;
          len_d = len_lo;
          cnt_d = 16'd2;
          if (len_lo < MinFrameLen || len_lo > max_len) begin
            phase_d = PH_LEN_HI;
          end else if (len_lo == MinFrameLen) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          crc_d = crc_upd;
          cnt_d = cnt_inc;
          if (cnt_inc >= crc_pos) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          cnt_d = cnt_inc;
          if (cnt_q == crc_pos) begin
            hi_d = rx_byte_i;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end
        default: phase_d = PH_LEN_HI;
      endcase
    end
  end

  // result generation
  always_comb begin
    emit     = 1'b0;
    status_d = status_q;
    olen_d   = olen_q;
    occ_d    = occ_q;
    orc_d    = orc_q;
    case (phase_cur)
      PH_LEN_LO: begin
        olen_d = len_lo;
        occ_d  = '0;
        orc_d  = '0;
        if (len_lo < MinFrameLen) begin
          emit     = 1'b1;
          status_d = STATUS_SHORT;
        end else if (len_lo > max_len) begin
          emit     = 1'b1;
          status_d = STATUS_LONG;
        end
      end
      PH_CRC: begin
        olen_d = len_q;
        occ_d  = crc_q;
        orc_d  = rx_crc;
        if (cnt_q != crc_pos) begin
          emit     = 1'b1;
          status_d = (rx_crc == crc_q) ? STATUS_OK : STATUS_MISMATCH;
        end
      end
      default: emit = 1'b0;
    endcase
    emit        = emit && accept;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN_HI;
      cnt_q       <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      olen_q   <= olen_d;
      occ_q    <= occ_d;
      orc_q    <= orc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_length_o = olen_q;
  assign computed_crc_o = occ_q;
  assign received_crc_o = orc_q;

endmodule

// ----- hw/rtl/clfc_cfg_regs.sv -----
// APB-style configuration register block: holds the maximum frame length.
// Depends on clfc_pkg.

module clfc_cfg_regs import clfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [LenW-1:0]   max_len_o
);

  logic [LenW-1:0] max_len_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegMaxFrameLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (wr_en) begin
      max_len_q <= pwdata[LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxFrameLen) begin
      prdata = {{(PdataW-LenW){1'b0}}, max_len_q};
    end
  end

  assign max_len_o = max_len_q;

endmodule

// ----- hw/rtl/clfc_checker.sv -----
// Port-level checks for the frame checker, bound to the top level.
// Depends on clfc_pkg and crc_length_frame_checker.

module clfc_checker import clfc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      status_o,
  input logic [LenW-1:0] frame_length_o,
  input logic [CrcW-1:0] computed_crc_o,
  input logic [CrcW-1:0] received_crc_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(frame_length_o) && $stable(computed_crc_o) && $stable(received_crc_o))
    else $error("result changed while stalled");

  a_len_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_SHORT || status_o == STATUS_LONG)
      |-> computed_crc_o == '0 && received_crc_o == '0)
    else $error("length error with nonzero crc fields");

  a_crc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_OK || status_o == STATUS_MISMATCH)
      |-> (status_o == STATUS_OK) == (computed_crc_o == received_crc_o))
    else $error("crc status disagrees with crc fields");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_SHORT |-> frame_length_o < MinFrameLen)
    else $error("short status with valid length");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_SHORT |-> frame_length_o >= MinFrameLen)
    else $error("result with length below minimum");

endmodule

bind crc_length_frame_checker clfc_checker u_clfc_checker (.*);

// ----- sim/crc16_xmodem_pkg.sv -----
// Byte-wise CRC-16/XMODEM update used to build frames and to predict reports.
// Depends on clfc_pkg for the polynomial and widths.

package crc16_xmodem_pkg;
  import clfc_pkg::*;

  function automatic logic [CrcW-1:0] crc16_xmodem_next(logic [CrcW-1:0] crc,
                                                        logic [ByteW-1:0] b);
    logic [CrcW-1:0] acc;
    logic            feedback;
    acc = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      feedback = acc[CrcW-1] ^ b[i];
      acc = {acc[CrcW-2:0], 1'b0};
      if (feedback) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

endpackage

// ----- sim/crc_length_frame_checker_monitor.sv -----
// Frame checker monitor: tracks framing and CRC of every accepted byte, compares
// each report with the oldest predicted one, and checks max frame length reads.
// Depends on clfc_pkg and crc16_xmodem_pkg.

module crc_length_frame_checker_monitor
  import clfc_pkg::*;
  import crc16_xmodem_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic              sync_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [LenW-1:0]   frame_length_i,
  input  logic [CrcW-1:0]   computed_crc_i,
  input  logic [CrcW-1:0]   received_crc_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic [PdataW-1:0] prdata,
  input  logic              pready,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       reports_o
);

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] frame_length;
    logic [CrcW-1:0] computed_crc;
    logic [CrcW-1:0] received_crc;
  } frame_report_t;

  frame_report_t    expected_reports[$];
  frame_report_t    fresh_report;
  frame_report_t    want;
  frame_report_t    got;
  phase_e           frame_phase;
  logic [LenW-1:0]  byte_count;
  logic [LenW-1:0]  length_value;
  logic [LenW-1:0]  max_len;
  logic [CrcW-1:0]  running_crc;
  logic [ByteW-1:0] crc_hi;

  assign pending_o = expected_reports.size();

  function automatic bit track_byte(input logic [ByteW-1:0] b, input logic s,
                                    output frame_report_t rep);
    rep = '0;
    if (s) begin
      frame_phase = PH_LEN_HI;
    end
    case (frame_phase)
      PH_LEN_HI: begin
        running_crc = crc16_xmodem_next(CrcInit, b);
        length_value = {b, 8'h00};
        byte_count = 16'd1;
        crc_hi = '0;
        frame_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        running_crc = crc16_xmodem_next(running_crc, b);
        length_value[ByteW-1:0] = b;
        byte_count = 16'd2;
        rep.frame_length = length_value;
        if (length_value < MinFrameLen) begin
          rep.status = STATUS_SHORT;
          frame_phase = PH_LEN_HI;
          return 1'b1;
        end
        if (length_value > max_len) begin
          rep.status = STATUS_LONG;
          frame_phase = PH_LEN_HI;
          return 1'b1;
        end
        frame_phase = (length_value == MinFrameLen) ? PH_CRC : PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        running_crc = crc16_xmodem_next(running_crc, b);
        byte_count = byte_count + 16'd1;
        if (byte_count >= length_value - CrcBytes) begin
          frame_phase = PH_CRC;
        end
        return 1'b0;
      end
      default: begin
        if (byte_count == length_value - CrcBytes) begin
          crc_hi = b;
          byte_count = byte_count + 16'd1;
          return 1'b0;
        end
        rep.frame_length = length_value;
        rep.computed_crc = running_crc;
        rep.received_crc = {crc_hi, b};
        rep.status = (rep.received_crc == running_crc) ? STATUS_OK : STATUS_MISMATCH;
        byte_count = byte_count + 16'd1;
        frame_phase = PH_LEN_HI;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase = PH_LEN_HI;
      byte_count = '0;
      length_value = '0;
      running_crc = '0;
      crc_hi = '0;
      max_len = MaxLenReset;
      expected_reports.delete();
      mismatches_o = 0;
      reports_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (track_byte(rx_byte_i, sync_i, fresh_report)) begin
          expected_reports.push_back(fresh_report);
        end
      end

      if (out_valid_i && out_ready_i) begin
        got.status = status_e'(status_i);
        got.frame_length = frame_length_i;
        got.computed_crc = computed_crc_i;
        got.received_crc = received_crc_i;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report: status %0d length %0d crc %h/%h", $time,
                   got.status, got.frame_length, got.computed_crc, got.received_crc);
          mismatches_o++;
        end else begin
          want = expected_reports.pop_front();
          if (got != want) begin
            mismatches_o++;
            if (got.status != want.status)
              $display("%0t: report %0d status expected %0d got %0d", $time, reports_o,
                       want.status, got.status);
            if (got.frame_length != want.frame_length)
              $display("%0t: report %0d frame_length expected %0d got %0d", $time,
                       reports_o, want.frame_length, got.frame_length);
            if (got.computed_crc != want.computed_crc)
              $display("%0t: report %0d computed_crc expected %h got %h", $time,
                       reports_o, want.computed_crc, got.computed_crc);
            if (got.received_crc != want.received_crc)
              $display("%0t: report %0d received_crc expected %h got %h", $time,
                       reports_o, want.received_crc, got.received_crc);
          end
          reports_o++;
        end
      end

      if (psel && penable && pready && paddr[PaddrW-1:2] == RegMaxFrameLen) begin
        if (pwrite) begin
          max_len = pwdata[LenW-1:0];
        end else if (prdata[LenW-1:0] != max_len) begin
          $display("%0t: max_frame_length read expected %0d got %0d", $time, max_len,
                   prdata[LenW-1:0]);
          mismatches_o++;
        end
      end
    end
  end

endmodule

// ----- sim/crc_length_frame_checker_test.sv -----
// Top of the frame checker testbench: clock, reset, byte stream and register
// stimulus with random idling; verdict from the monitor's mismatch count.
// Depends on clfc_pkg, crc16_xmodem_pkg, the monitor and crc_length_frame_checker.

module crc_length_frame_checker_test;
  import clfc_pkg::*;
  import crc16_xmodem_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseBytes  = 330;
  localparam logic [PaddrW-1:0] MaxLenAddr = {RegMaxFrameLen, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  rx_byte_i = '0;
  logic              sync_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [LenW-1:0]   frame_length_o;
  logic [CrcW-1:0]   computed_crc_o;
  logic [CrcW-1:0]   received_crc_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned reports;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  logic [LenW-1:0] cur_max = MaxLenReset;
  bit need_sync = 1'b1;

  crc_length_frame_checker dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i, .sync_i,
    .out_valid_o, .out_ready_i, .status_o, .frame_length_o, .computed_crc_o,
    .received_crc_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  crc_length_frame_checker_monitor monitor (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .rx_byte_i, .sync_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .frame_length_i(frame_length_o), .computed_crc_i(computed_crc_o),
    .received_crc_i(received_crc_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches_o(mismatches), .pending_o(pending), .reports_o(reports)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input logic s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    sync_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MaxLenAddr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      cur_max = data[LenW-1:0];
    end
  endtask

  task automatic send_frame(input logic [LenW-1:0] len, input bit bad_crc,
                            input logic lead_sync);
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] b;
    crc = crc16_xmodem_next(CrcInit, len[15:8]);
    crc = crc16_xmodem_next(crc, len[7:0]);
    push_byte(len[15:8], lead_sync);
    push_byte(len[7:0], 1'b0);
    if (len < MinFrameLen || len > cur_max) begin
      return;
    end
    repeat (len - MinFrameLen) begin
      b = ByteW'($urandom);
      crc = crc16_xmodem_next(crc, b);
      push_byte(b, 1'b0);
    end
    if (bad_crc) begin
      crc = crc ^ CrcW'($urandom_range(16'hffff, 1));
    end
    push_byte(crc[15:8], 1'b0);
    push_byte(crc[7:0], 1'b0);
  endtask

  // drop the frame before its last byte; the next frame must resync
  task automatic send_partial(input logic [LenW-1:0] len, input int unsigned extra);
    push_byte(len[15:8], 1'b1);
    push_byte(len[7:0], 1'b0);
    repeat (extra) push_byte(ByteW'($urandom), 1'b0);
    need_sync = 1'b1;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop;
    int unsigned pick;
    int unsigned top_len;
    logic [LenW-1:0] len;
    logic lead;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      top_len = ($urandom_range(9) == 0) ? 200 : 20;
      if (top_len > 32'(cur_max)) begin
        top_len = 32'(cur_max);
      end
      len = LenW'($urandom_range(top_len, MinFrameLen));
      lead = need_sync ? 1'b1 : 1'($urandom_range(1));
      need_sync = 1'b0;
      if (pick < 60) begin
        send_frame(len, 1'b0, lead);
      end else if (pick < 70) begin
        send_frame(len, 1'b1, lead);
      end else if (pick < 78) begin
        if (cur_max == 16'hffff || $urandom_range(1) == 0) begin
          len = LenW'($urandom_range(MinFrameLen - 1, 0));
        end else begin
          len = LenW'($urandom_range(16'hffff, 32'(cur_max) + 1));
        end
        send_frame(len, 1'b0, lead);
      end else if (pick < 88) begin
        send_partial(len, $urandom_range(32'(len) - 3, 0));
      end else begin
        repeat ($urandom_range(8, 1)) push_byte(ByteW'($urandom), 1'($urandom_range(1)));
        need_sync = 1'b1;
      end
    end
    wait_idle();
  endtask

  initial begin
    src_idle_pct = 23;
    sink_stall_pct = 80;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    apb_cycle(1'b0, '0);
    send_frame(16'd4, 1'b0, 1'b1);
    send_frame(16'd4, 1'b1, 1'b0);
    send_frame(16'd0, 1'b0, 1'b0);
    send_frame(16'd3, 1'b0, 1'b1);
    send_frame(16'hffff, 1'b0, 1'b0);
    send_frame(16'd101, 1'b0, 1'b0);
    send_frame(16'd5, 1'b0, 1'b0);
    send_partial(16'd8, 2);
    send_frame(16'd4, 1'b0, 1'b1);
    wait_idle();

    apb_cycle(1'b1, 32'd2);
    apb_cycle(1'b0, '0);
    send_frame(16'd3, 1'b0, 1'b1);
    send_frame(16'd4, 1'b0, 1'b0);
    wait_idle();

    apb_cycle(1'b1, 32'd4);
    send_frame(16'd4, 1'b0, 1'b1);
    send_frame(16'd5, 1'b0, 1'b0);
    send_frame(16'd4, 1'b1, 1'b0);
    wait_idle();

    apb_cycle(1'b1, 32'd64);
    apb_cycle(1'b0, '0);
    need_sync = 1'b1;
    run_random(PhaseBytes);

    src_idle_pct = 80;
    sink_stall_pct = 23;
    apb_cycle(1'b1, 32'($urandom_range(40, 8)));
    run_random(PhaseBytes);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    apb_cycle(1'b1, 32'hffff);
    apb_cycle(1'b0, '0);
    run_random(PhaseBytes);

    $display("Sent %0d bytes (good, corrupt, bad-length, dropped and noise frames)",
             bytes_sent);
    $display("Checked %0d reports under max frame lengths from 2 to 65535", reports);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/clfc_pkg.sv
hw/rtl/clfc_cfg_regs.sv
hw/rtl/crc_length_frame_checker.sv
hw/rtl/clfc_checker.sv
sim/crc16_xmodem_pkg.sv
sim/crc_length_frame_checker_monitor.sv
sim/crc_length_frame_checker_test.sv
